### sv/ealu_pkg.sv
package ealu_pkg;

    typedef enum logic [3:0] {
        OP_ADC  = 4'd0,
        OP_SBC  = 4'd1,
        OP_AND  = 4'd2,
        OP_ORA  = 4'd3,
        OP_EOR  = 4'd4,
        OP_CMP  = 4'd5,
        OP_BIT  = 4'd6,
        OP_ASL  = 4'd7,
        OP_ROL  = 4'd8,
        OP_LSR  = 4'd9,
        OP_ROR  = 4'd10,
        OP_INC  = 4'd11,
        OP_DEC  = 4'd12,
        OP_LOAD = 4'd13
    } t_opcode;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] MASK_NZ   = 8'h82;
    localparam logic [7:0] MASK_NZC  = 8'h83;
    localparam logic [7:0] MASK_NZV  = 8'hC2;
    localparam logic [7:0] MASK_NZCV = 8'hC3;
    localparam logic [7:0] MASK_NONE = 8'h00;

    localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
    localparam logic [3:0] BCD_ADJUST    = 4'd6;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] a_operand;
        logic [7:0] b_operand;
        logic [7:0] flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] flags_out;
    } t_alu_out;

    // N and Z of a result byte, placed at their status positions
    function automatic logic [7:0] nz_of(input logic [7:0] v);
        logic [7:0] f;
        f = 8'h00;
        f[FLAG_Z] = (v == 8'h00);
        f[FLAG_N] = v[7];
        return f;
    endfunction

endpackage

### sv/eight_bit_alu_bcd_flags.sv
// Eight-bit ALU with packed-BCD add/subtract and processor status update.
//
// Input: raise start with i_opcode, i_a_operand, i_b_operand and i_flags_in.
// A beat is taken at every rising edge where start is high and busy is low.
// busy never rises, so a new operation can be issued on every cycle.
//
// Output: o_valid is high for exactly one cycle with o_result and
// o_flags_out. The receiver has no way to hold results off; it must take
// each beat in the cycle it appears.
//
// Data path: input register, then one combinational pass, then the result
// register. Throughput: one operation per cycle, set by that single pass.
//
// Reset (i_rst_n low, synchronous) clears both valid bits; beats in flight
// are dropped. Only N, Z, C and V change; other status bits pass through.
module eight_bit_alu_bcd_flags (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] i_opcode,
    input  logic [7:0] i_a_operand,
    input  logic [7:0] i_b_operand,
    input  logic [7:0] i_flags_in,
    output logic       o_valid,
    output logic [7:0] o_result,
    output logic [7:0] o_flags_out
);

    logic                r_in_vld;
    ealu_pkg::t_alu_in   r_in;
    logic                r_out_vld;
    ealu_pkg::t_alu_out  r_out;
    ealu_pkg::t_alu_out  n_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start & ~busy;
            r_out_vld <= r_in_vld;
        end
    end

    // payload registers: capture on every beat, hold otherwise
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in.opcode    <= i_opcode;
            r_in.a_operand <= i_a_operand;
            r_in.b_operand <= i_b_operand;
            r_in.flags_in  <= i_flags_in;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    ealu_core u_core (
        .i_op  (r_in),
        .o_res (n_out)
    );

    assign o_valid     = r_out_vld;
    assign o_result    = r_out.result;
    assign o_flags_out = r_out.flags_out;

endmodule

### sv/ealu_core.sv
module ealu_core (
    input  ealu_pkg::t_alu_in  i_op,
    output ealu_pkg::t_alu_out o_res
);

    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] p;
    logic       c_in;
    logic       dec_mode;

    logic [8:0] bin_sum;
    logic [8:0] bin_diff;
    logic [8:0] cmp_diff;
    logic       borrow;

    logic [5:0] add_lo;
    logic [5:0] add_hi;
    logic       add_hi_n;
    logic [7:0] add_res;
    logic [7:0] add_flags;

    logic [4:0] sub_lo;
    logic [4:0] sub_hi;
    logic [3:0] sub_lo_adj;
    logic [3:0] sub_hi_adj;
    logic [7:0] sub_res;
    logic [7:0] sub_flags;

    logic [7:0] r;
    logic [7:0] f;
    logic [7:0] mask;

    assign a        = i_op.a_operand;
    assign b        = i_op.b_operand;
    assign p        = i_op.flags_in;
    assign c_in     = p[ealu_pkg::FLAG_C];
    assign dec_mode = p[ealu_pkg::FLAG_D];
    assign borrow   = ~c_in;

    assign bin_sum  = {1'b0, a} + {1'b0, b} + {8'h00, c_in};
    assign bin_diff = {1'b0, a} - {1'b0, b} - {8'h00, borrow};
    assign cmp_diff = {1'b0, a} - {1'b0, b};

    // decimal add: adjust low digit, then high digit with the low carry; binary sum when D is clear
    always_comb begin
        add_lo = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'b00000, c_in};
        if (add_lo > {2'b00, ealu_pkg::BCD_MAX_DIGIT}) begin
            add_lo = add_lo + {2'b00, ealu_pkg::BCD_ADJUST};
        end
        add_hi = {2'b00, a[7:4]} + {2'b00, b[7:4]} + {5'b00000, (add_lo > 6'd15)};
        add_hi_n = add_hi[3];
        add_flags = 8'h00;
        add_flags[ealu_pkg::FLAG_Z] = (bin_sum[7:0] == 8'h00);
        add_flags[ealu_pkg::FLAG_N] = add_hi_n;
        add_flags[ealu_pkg::FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ add_hi_n);
        if (add_hi > {2'b00, ealu_pkg::BCD_MAX_DIGIT}) begin
            add_hi = add_hi + {2'b00, ealu_pkg::BCD_ADJUST};
        end
        add_flags[ealu_pkg::FLAG_C] = (add_hi > 6'd15);
        add_res = {add_hi[3:0], add_lo[3:0]};
        if (!dec_mode) begin
            add_res = bin_sum[7:0];
            add_flags = ealu_pkg::nz_of(bin_sum[7:0]);
            add_flags[ealu_pkg::FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ bin_sum[7]);
            add_flags[ealu_pkg::FLAG_C] = bin_sum[8];
        end
    end

    // decimal subtract: flags always from the binary difference; binary result when D is clear
    always_comb begin
        sub_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, borrow};
        sub_lo_adj = sub_lo[3:0] - (sub_lo[4] ? ealu_pkg::BCD_ADJUST : 4'h0);
        sub_hi = {1'b0, a[7:4]} - {1'b0, b[7:4]} - {4'h0, sub_lo[4]};
        sub_hi_adj = sub_hi[3:0] - (sub_hi[4] ? ealu_pkg::BCD_ADJUST : 4'h0);
        sub_flags = ealu_pkg::nz_of(bin_diff[7:0]);
        sub_flags[ealu_pkg::FLAG_V] = (a[7] ^ b[7]) & (a[7] ^ bin_diff[7]);
        sub_flags[ealu_pkg::FLAG_C] = ~bin_diff[8];
        sub_res = dec_mode ? {sub_hi_adj, sub_lo_adj} : bin_diff[7:0];
    end

    always_comb begin
        r    = a;
        f    = 8'h00;
        mask = ealu_pkg::MASK_NZ;
        case (i_op.opcode)
            ealu_pkg::OP_ADC: begin
                r    = add_res;
                f    = add_flags;
                mask = ealu_pkg::MASK_NZCV;
            end
            ealu_pkg::OP_SBC: begin
                r    = sub_res;
                f    = sub_flags;
                mask = ealu_pkg::MASK_NZCV;
            end
            ealu_pkg::OP_AND: begin
                r = a & b;
                f = ealu_pkg::nz_of(r);
            end
            ealu_pkg::OP_ORA: begin
                r = a | b;
                f = ealu_pkg::nz_of(r);
            end
            ealu_pkg::OP_EOR: begin
                r = a ^ b;
                f = ealu_pkg::nz_of(r);
            end
            ealu_pkg::OP_CMP: begin
                f = ealu_pkg::nz_of(cmp_diff[7:0]);
                f[ealu_pkg::FLAG_C] = ~cmp_diff[8];
                mask = ealu_pkg::MASK_NZC;
            end
            ealu_pkg::OP_BIT: begin
                f[ealu_pkg::FLAG_Z] = ((a & b) == 8'h00);
                f[ealu_pkg::FLAG_N] = b[7];
                f[ealu_pkg::FLAG_V] = b[6];
                mask = ealu_pkg::MASK_NZV;
            end
            ealu_pkg::OP_ASL, ealu_pkg::OP_ROL: begin
                r = {b[6:0], (i_op.opcode == ealu_pkg::OP_ROL) & c_in};
                f = ealu_pkg::nz_of(r);
                f[ealu_pkg::FLAG_C] = b[7];
                mask = ealu_pkg::MASK_NZC;
            end
            ealu_pkg::OP_LSR, ealu_pkg::OP_ROR: begin
                r = {(i_op.opcode == ealu_pkg::OP_ROR) & c_in, b[7:1]};
                f = ealu_pkg::nz_of(r);
                f[ealu_pkg::FLAG_C] = b[0];
                mask = ealu_pkg::MASK_NZC;
            end
            ealu_pkg::OP_INC: begin
                r = b + 8'h01;
                f = ealu_pkg::nz_of(r);
            end
            ealu_pkg::OP_DEC: begin
                r = b - 8'h01;
                f = ealu_pkg::nz_of(r);
            end
            ealu_pkg::OP_LOAD: begin
                r = b;
                f = ealu_pkg::nz_of(r);
            end
            default: begin
                mask = ealu_pkg::MASK_NONE;
            end
        endcase
    end

    assign o_res.result    = r;
    assign o_res.flags_out = (p & ~mask) | (f & mask);

endmodule
